// File: rtl/rdrg_pkg.sv
// Package for the grouped radix digit renderer: state and base codes,
// shared sizes, separator codes and the digit character lookup.
// No dependencies.
package rdrg_pkg;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } rdrg_base_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_XFER,
    ST_STRIP,
    ST_EMIT
  } rdrg_state_e;

  typedef enum logic [1:0] {
    CFG_BASE  = 2'd0,
    CFG_WIDTH = 2'd1,
    CFG_SIGN  = 2'd2
  } rdrg_cfg_e;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned DIG_REG_W  = 4 * BCD_DIGITS;

  // Digit slots each base starts from before leading zeros are dropped
  localparam logic [6:0] SLOTS_BIN = 7'd64;
  localparam logic [6:0] SLOTS_OCT = 7'd22;
  localparam logic [6:0] SLOTS_DEC = 7'd20;
  localparam logic [6:0] SLOTS_HEX = 7'd16;

  localparam logic [6:0] SEP_COMMA = 7'd44;
  localparam logic [6:0] SEP_UNDER = 7'd95;

  localparam logic [6:0] RST_WIDTH = 7'd64;

  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_in;
  } rdrg_conv_ctl_t;

  function automatic logic [6:0] digit_ascii(input logic [3:0] d);
    logic [6:0] r;
    if (d < 4'd10) r = 7'd48 + {3'b000, d};
    else r = 7'd55 + {3'b000, d};
    return r;
  endfunction

endpackage

// File: rtl/rdrg_bcd_conv.sv
// Bit-serial binary to BCD accumulator (shift and add-3), one input bit a cycle while shift is set.
// Depends on rdrg_pkg.
module rdrg_bcd_conv
  import rdrg_pkg::*;
(
  input  logic                 clk_i,
  input  rdrg_conv_ctl_t       ctl_i,
  output logic [DIG_REG_W-1:0] bcd_o
);

  logic [DIG_REG_W-1:0] bcd_q;
  logic [DIG_REG_W-1:0] bcd_d;
  logic [DIG_REG_W-1:0] adj;

  always_comb begin
    logic [3:0] d;
    d = 4'd0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      d = bcd_q[4*i +: 4];
      adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    bcd_d = bcd_q;
    if (ctl_i.clear) begin
      bcd_d = '0;
    end else if (ctl_i.shift) begin
      bcd_d = {adj[DIG_REG_W-2:0], ctl_i.bit_in};
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  assign bcd_o = bcd_q;

endmodule

// File: rtl/radix_digit_render_grouped_unit.sv
// Top level of the grouped radix digit renderer: config registers, sequencer,
// digit shift register and output fields. Depends on rdrg_pkg and rdrg_bcd_conv.
//
// ch  | dir | handshake               | payload
// ----+-----+-------------------------+----------------------------------------------------
// in  | in  | in_valid_i/in_stall_o   | value_i
// out | out | out_valid_o/out_stall_i | digit_char_o sep_before_o sep_char_o negative_o last_o
// cfg | in  | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// Decimal: load, shift-and-add-3 over all 64 value bits, transfer, strip, then the digits out.
// Binary/octal/hex: load, strip, then the digits out; slots 64/22/16.
// The decimal path goes through the bit-serial BCD loop; the others load the strip shifter directly.
// One word is worked on at a time; in_stall_o stays high until its last digit leaves.
// Output stall holds the digit register, so the shown digit does not move.
// Reset sets base decimal, width 64, signed decimal on.
module radix_digit_render_grouped_unit
  import rdrg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [VALUE_W-1:0]   value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [6:0]           digit_char_o,
  output logic                 sep_before_o,
  output logic [6:0]           sep_char_o,
  output logic                 negative_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [6:0]           cfg_data_i
);

  rdrg_base_e  base_q;
  logic [6:0]  width_q;
  logic        sign_q;

  rdrg_state_e state_q, state_d;
  logic [VALUE_W-1:0]   src_q, src_d;
  logic [5:0]           conv_cnt_q, conv_cnt_d;
  logic [DIG_REG_W-1:0] sr_q, sr_d;
  logic [6:0]           cnt_q, cnt_d;
  logic [1:0]           grp_q, grp_d;
  logic                 first_q, first_d;
  logic                 neg_q, neg_d;

  logic [6:0]           eff_w;
  logic [6:0]           eff_wm1;
  logic [VALUE_W-1:0]   mask;
  logic [VALUE_W-1:0]   masked;
  logic [VALUE_W-1:0]   work;
  logic                 load_neg;
  logic [3:0]           top_dig;
  logic [DIG_REG_W-1:0] sr_shift;
  logic [1:0]           grp_dec;
  logic                 in_acc;
  logic                 out_acc;
  logic [DIG_REG_W-1:0] bcd;
  rdrg_conv_ctl_t       conv_ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_DEC;
      width_q <= RST_WIDTH;
      sign_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BASE:  base_q  <= rdrg_base_e'(cfg_data_i[1:0]);
        CFG_WIDTH: width_q <= cfg_data_i;
        CFG_SIGN:  sign_q  <= cfg_data_i[0];
        default:   ;
      endcase
    end
  end

  // Clamp width into 1..64
  always_comb begin
    if (width_q == 7'd0) eff_w = 7'd1;
    else if (width_q > 7'd64) eff_w = 7'd64;
    else eff_w = width_q;
  end
  assign eff_wm1 = eff_w - 7'd1;

  always_comb begin
    for (int j = 0; j < VALUE_W; j++) begin
      mask[j] = (7'(j) < eff_w);
    end
  end

  assign masked   = value_i & mask;
  assign load_neg = (base_q == BASE_DEC) && sign_q && masked[eff_wm1[5:0]];
  assign work     = load_neg ? ((~masked + 64'd1) & mask) : masked;

  // Top digit and one-digit left shift for the current base
  always_comb begin
    case (base_q)
      BASE_BIN: begin
        top_dig  = {3'b000, sr_q[DIG_REG_W-1]};
        sr_shift = {sr_q[DIG_REG_W-2:0], 1'b0};
      end
      BASE_OCT: begin
        top_dig  = {1'b0, sr_q[DIG_REG_W-1 -: 3]};
        sr_shift = {sr_q[DIG_REG_W-4:0], 3'b000};
      end
      default: begin
        top_dig  = sr_q[DIG_REG_W-1 -: 4];
        sr_shift = {sr_q[DIG_REG_W-5:0], 4'b0000};
      end
    endcase
  end

  // Digits left modulo group length, counting down with wrap
  always_comb begin
    if (grp_q != 2'd0) grp_dec = grp_q - 2'd1;
    else if (base_q == BASE_BIN || base_q == BASE_HEX) grp_dec = 2'd3;
    else grp_dec = 2'd2;
  end

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    conv_cnt_d  = conv_cnt_q;
    sr_d        = sr_q;
    cnt_d       = cnt_q;
    grp_d       = grp_q;
    first_d     = first_q;
    neg_d       = neg_q;
    conv_ctl    = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          neg_d = load_neg;
          case (base_q)
            BASE_DEC: begin
              src_d          = work;
              conv_cnt_d     = 6'd63;
              conv_ctl.clear = 1'b1;
              state_d        = ST_CONV;
            end
            BASE_OCT: begin
              sr_d    = {2'b00, work, 14'd0};
              cnt_d   = SLOTS_OCT;
              grp_d   = 2'd1;
              state_d = ST_STRIP;
            end
            BASE_HEX: begin
              sr_d    = {work, 16'd0};
              cnt_d   = SLOTS_HEX;
              grp_d   = 2'd0;
              state_d = ST_STRIP;
            end
            default: begin
              sr_d    = {work, 16'd0};
              cnt_d   = SLOTS_BIN;
              grp_d   = 2'd0;
              state_d = ST_STRIP;
            end
          endcase
        end
      end
      ST_CONV: begin
        // feed the value MSB first into the BCD accumulator
        conv_ctl.shift  = 1'b1;
        conv_ctl.bit_in = src_q[VALUE_W-1];
        src_d           = {src_q[VALUE_W-2:0], 1'b0};
        conv_cnt_d      = conv_cnt_q - 6'd1;
        if (conv_cnt_q == 6'd0) state_d = ST_XFER;
      end
      ST_XFER: begin
        sr_d    = bcd;
        cnt_d   = SLOTS_DEC;
        grp_d   = 2'd2;
        state_d = ST_STRIP;
      end
      ST_STRIP: begin
        // drop leading zeros; binary keeps the configured width
        if (cnt_q > 7'd1 && top_dig == 4'd0 && (base_q != BASE_BIN || cnt_q > eff_w)) begin
          sr_d  = sr_shift;
          cnt_d = cnt_q - 7'd1;
          grp_d = grp_dec;
        end else begin
          first_d = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_acc) begin
          if (cnt_q == 7'd1) begin
            state_d = ST_IDLE;
          end else begin
            sr_d    = sr_shift;
            cnt_d   = cnt_q - 7'd1;
            grp_d   = grp_dec;
            first_d = 1'b0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      conv_cnt_q <= 6'd0;
      cnt_q      <= 7'd0;
      grp_q      <= 2'd0;
      first_q    <= 1'b0;
      neg_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      conv_cnt_q <= conv_cnt_d;
      cnt_q      <= cnt_d;
      grp_q      <= grp_d;
      first_q    <= first_d;
      neg_q      <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    sr_q  <= sr_d;
  end

  rdrg_bcd_conv u_bcd (
    .clk_i (clk_i),
    .ctl_i (conv_ctl),
    .bcd_o (bcd)
  );

  assign digit_char_o = digit_ascii(top_dig);
  assign sep_before_o = !first_q && (grp_q == 2'd0);
  assign sep_char_o   = (base_q == BASE_DEC) ? SEP_COMMA : SEP_UNDER;
  assign negative_o   = neg_q;
  assign last_o       = (cnt_q == 7'd1);

endmodule

// File: rtl/rdrg_checker.sv
// Port-level checks for the grouped radix digit renderer, bound to the top level.
// Depends on radix_digit_render_grouped_unit.
module rdrg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] digit_char_o,
  input logic       last_o
);

  // a stalled digit stays up and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digit_char_o))
    else $error("stalled output word changed");

  // a new word never shows a digit the next cycle
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("digit shown right after input accept");

  // no input taken while digits are still going out
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while emitting");

  // the last digit closes the word
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o)
    else $error("output continued after last digit");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((digit_char_o >= 7'd48 && digit_char_o <= 7'd57) ||
                     (digit_char_o >= 7'd65 && digit_char_o <= 7'd70)))
    else $error("digit character out of range");

endmodule

bind radix_digit_render_grouped_unit rdrg_checker u_rdrg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .digit_char_o (digit_char_o),
  .last_o       (last_o)
);
